// ----- sv/lidar_gap_follow_steer_top_assert.svh -----
// Assertion macros shared by the gap-follow steering RTL.
`ifndef LIDAR_GAP_FOLLOW_STEER_TOP_ASSERT_SVH
`define LIDAR_GAP_FOLLOW_STEER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LGFS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LGFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lgfs_pkg.sv -----
// Types, constants and helper function for the gap-follow steering block.
package lgfs_pkg;

  localparam int MaxRays     = 2048;
  localparam int CenterIndex = 540;
  localparam int CenterRays  = 5;

  localparam int RangeW = 16;
  localparam int RayW   = $clog2(MaxRays);
  localparam int LenW   = $clog2(MaxRays + 1);
  localparam int CsumW  = $clog2(CenterRays * 65535 + 1);
  localparam int SteerW = 23;

  localparam int SteerMax = 4194303;
  localparam int SteerMin = -4194304;

  // Centre window bounds, inclusive.
  localparam logic [RayW-1:0] CwLo = RayW'(CenterIndex - CenterRays / 2);
  localparam logic [RayW-1:0] CwHi = RayW'(CenterIndex - CenterRays / 2 + CenterRays - 1);

  // floor(x / CenterRays) = (x * DivMul) >> DivShift, exact for x < 2**CsumW.
  localparam int DivShift = CsumW + $clog2(CenterRays);
  localparam int DivMulW  = CsumW + 1;
  localparam logic [DivMulW-1:0] DivMul =
    DivMulW'(((64'd1 << DivShift) + 64'(CenterRays) - 64'd1) / 64'(CenterRays));

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = SteerW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OBST_THR   = 3'd0,
    CFG_FREE_LIM   = 3'd1,
    CFG_STEER_OFS  = 3'd2,
    CFG_HALF_STEP  = 3'd3,
    CFG_NEAR_DIST  = 3'd4,
    CFG_FAR_DIST   = 3'd5,
    CFG_TURN_SPEED = 3'd6,
    CFG_SPEED_SLP  = 3'd7
  } lgfs_cfg_idx_e;

  typedef struct packed {
    logic [RangeW-1:0]        obst_thr;
    logic [RangeW-1:0]        free_lim;
    logic signed [SteerW-1:0] steer_ofs;
    logic [15:0]              half_step;
    logic [RangeW-1:0]        near_dist;
    logic [RangeW-1:0]        far_dist;
    logic [15:0]              turn_speed;
    logic [15:0]              speed_slope;
  } lgfs_cfg_t;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [RayW-1:0] start;
    logic [RayW-1:0] stop;
  } lgfs_best_t;

  // Scan summary handed from the ray stage to the command stages.
  typedef struct packed {
    lgfs_best_t       best;
    logic [CsumW-1:0] csum;
    logic             cinv;
  } lgfs_snap_t;

  // Offer a run as best gap; after is the index one past its last ray.
  function automatic lgfs_best_t lgfs_offer(lgfs_best_t best, logic [LenW-1:0] run,
                                            logic [LenW-1:0] after);
    lgfs_best_t      res;
    logic [LenW-1:0] st;
    logic [LenW-1:0] en;
    res = best;
    st  = after - run;
    en  = after - LenW'(1);
    if (run > best.len) begin
      res.len   = run;
      res.start = (run > after) ? '0 : st[RayW-1:0];
      res.stop  = (after == '0) ? '0 : en[RayW-1:0];
    end
    return res;
  endfunction

endpackage

// ----- sv/lidar_gap_follow_steer_top.sv -----
// Top level of the follow-the-gap lidar steering and speed block.
//
// Input channel: one lidar ray per beat (range_mm_i, invalid_i, last_ray_i),
// in ray order, handshaken by in_valid_i / in_ready_o. Rays are taken one
// per clock while in_ready_o is high; the ray stage updates the free-run,
// best-gap and centre-window state on each accepted beat.
// Output channel: one result beat per scan (steering_o, speed_mm_s_o,
// gap_length_o, gap_start_o) on out_valid_o / out_ready_i. A scan with a
// single last ray is legal, so results can also follow back to back.
// Path: the scan summary register loads at the edge that accepts the
// last-ray beat, then the steering/average stage, then the speed stage with
// the output register, which raises out_valid_o.
// Throughput is one ray per cycle while in_ready_o is high, set by the ray stage.
// Stall: with out_ready_i low the output, the middle stage and the summary
// register fill up in turn; in_ready_o then drops only once the summary
// register is full and cannot move on. Nothing is dropped.
// Reset (rst_ni low, async) clears the scan state and pipeline valid bits and
// loads the register defaults. Config writes (cfg_we_i, cfg_idx_i,
// cfg_data_i) take effect at once and are meant for an idle block.
module lidar_gap_follow_steer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lgfs_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [lgfs_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lgfs_pkg::RangeW-1:0]         range_mm_i,
  input  logic                                invalid_i,
  input  logic                                last_ray_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lgfs_pkg::SteerW-1:0]  steering_o,
  output logic [15:0]                         speed_mm_s_o,
  output logic [lgfs_pkg::LenW-1:0]           gap_length_o,
  output logic [lgfs_pkg::RayW-1:0]           gap_start_o
);
  import lgfs_pkg::*;

  lgfs_cfg_t  cfg;
  lgfs_snap_t snap;
  logic       snap_vld;
  logic       snap_rdy;

  // register file, defaults at reset
  lgfs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // per-ray stage, emits one summary per scan
  lgfs_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .range_mm_i (range_mm_i),
    .invalid_i  (invalid_i),
    .last_ray_i (last_ray_i),
    .snap_vld_o (snap_vld),
    .snap_rdy_i (snap_rdy),
    .snap_o     (snap)
  );

  // steering, centre average, speed, output register
  lgfs_cmd u_cmd (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .snap_vld_i   (snap_vld),
    .snap_rdy_o   (snap_rdy),
    .snap_i       (snap),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .steering_o   (steering_o),
    .speed_mm_s_o (speed_mm_s_o),
    .gap_length_o (gap_length_o),
    .gap_start_o  (gap_start_o)
  );

endmodule

// ----- sv/lgfs_cfg.sv -----
// Configuration register file of the gap-follow steering block.
module lgfs_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lgfs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [lgfs_pkg::CfgDataW-1:0]    cfg_data_i,
  output lgfs_pkg::lgfs_cfg_t              cfg_o
);
  import lgfs_pkg::*;

  lgfs_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (lgfs_cfg_idx_e'(cfg_idx_i))
        CFG_OBST_THR:   cfg_d.obst_thr    = cfg_data_i[RangeW-1:0];
        CFG_FREE_LIM:   cfg_d.free_lim    = cfg_data_i[RangeW-1:0];
        CFG_STEER_OFS:  cfg_d.steer_ofs   = $signed(cfg_data_i[SteerW-1:0]);
        CFG_HALF_STEP:  cfg_d.half_step   = cfg_data_i[15:0];
        CFG_NEAR_DIST:  cfg_d.near_dist   = cfg_data_i[RangeW-1:0];
        CFG_FAR_DIST:   cfg_d.far_dist    = cfg_data_i[RangeW-1:0];
        CFG_TURN_SPEED: cfg_d.turn_speed  = cfg_data_i[15:0];
        CFG_SPEED_SLP:  cfg_d.speed_slope = cfg_data_i[15:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.obst_thr    <= 16'd2500;
      cfg_q.free_lim    <= 16'd30000;
      cfg_q.steer_ofs   <= SteerW'(-1848115);
      cfg_q.half_step   <= 16'd1716;
      cfg_q.near_dist   <= 16'd1500;
      cfg_q.far_dist    <= 16'd5000;
      cfg_q.turn_speed  <= 16'd2000;
      cfg_q.speed_slope <= 16'd146;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/lgfs_scan.sv -----
// Per-ray stage: classifies rays, tracks free runs and the centre window.
`include "lidar_gap_follow_steer_top_assert.svh"

module lgfs_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lgfs_pkg::lgfs_cfg_t           cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lgfs_pkg::RangeW-1:0]   range_mm_i,
  input  logic                          invalid_i,
  input  logic                          last_ray_i,
  output logic                          snap_vld_o,
  input  logic                          snap_rdy_i,
  output lgfs_pkg::lgfs_snap_t          snap_o
);
  import lgfs_pkg::*;

  logic [RayW-1:0]  ray_q, ray_d;
  logic [LenW-1:0]  run_q, run_d;
  lgfs_best_t       best_q, best_d;
  logic [CsumW-1:0] csum_q, csum_d;
  logic             cinv_q, cinv_d;
  logic             snap_vld_q, snap_vld_d;
  lgfs_snap_t       snap_q, snap_d;

  logic             in_fire;
  logic             is_free;
  logic             in_win;
  logic [LenW-1:0]  run_mid;
  lgfs_best_t       best_mid;
  lgfs_best_t       best_fin;
  logic [CsumW-1:0] csum_nxt;
  logic             cinv_nxt;

  assign in_ready_o = !snap_vld_q || snap_rdy_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_free = invalid_i || (range_mm_i > cfg_i.free_lim) ||
                   (range_mm_i >= cfg_i.obst_thr);
  assign in_win  = (ray_q >= CwLo) && (ray_q <= CwHi);

  always_comb begin
    csum_nxt = csum_q;
    cinv_nxt = cinv_q;
    if (in_win) begin
      if (invalid_i) cinv_nxt = 1'b1;
      else           csum_nxt = csum_q + CsumW'(range_mm_i);
    end
  end

  // Obstacle closes the run; last ray closes a trailing run.
  always_comb begin
    if (is_free) begin
      run_mid  = (run_q < LenW'(MaxRays)) ? run_q + LenW'(1) : run_q;
      best_mid = best_q;
    end else begin
      run_mid  = '0;
      best_mid = lgfs_offer(best_q, run_q, LenW'(ray_q));
    end
    best_fin = lgfs_offer(best_mid, run_mid, LenW'(ray_q) + LenW'(1));
  end

  always_comb begin
    ray_d      = ray_q;
    run_d      = run_q;
    best_d     = best_q;
    csum_d     = csum_q;
    cinv_d     = cinv_q;
    snap_d     = snap_q;
    snap_vld_d = snap_rdy_i ? 1'b0 : snap_vld_q;
    if (in_fire) begin
      if (last_ray_i) begin
        ray_d      = '0;
        run_d      = '0;
        best_d     = '0;
        csum_d     = '0;
        cinv_d     = 1'b0;
        snap_d     = '{best: best_fin, csum: csum_nxt, cinv: cinv_nxt};
        snap_vld_d = 1'b1;
      end else begin
        ray_d  = (ray_q != RayW'(MaxRays - 1)) ? ray_q + RayW'(1) : ray_q;
        run_d  = run_mid;
        best_d = best_mid;
        csum_d = csum_nxt;
        cinv_d = cinv_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_q      <= '0;
      run_q      <= '0;
      best_q     <= '0;
      csum_q     <= '0;
      cinv_q     <= 1'b0;
      snap_vld_q <= 1'b0;
    end else begin
      ray_q      <= ray_d;
      run_q      <= run_d;
      best_q     <= best_d;
      csum_q     <= csum_d;
      cinv_q     <= cinv_d;
      snap_vld_q <= snap_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
  end

  assign snap_vld_o = snap_vld_q;
  assign snap_o     = snap_q;

  `LGFS_ASSERT_NEXT(a_scan_clear, in_fire && last_ray_i,
    ray_q == '0 && run_q == '0 && best_q.len == '0 && csum_q == '0 && snap_vld_q,
    "scan state not cleared after last ray")
  `LGFS_ASSERT_SAME(a_best_order, best_q.len != '0, best_q.start <= best_q.stop,
    "best gap start beyond its end")
  `LGFS_ASSERT_NEXT(a_ray_no_wrap, in_fire && !last_ray_i, ray_q != '0,
    "ray index wrapped inside a scan")

endmodule

// ----- sv/lgfs_cmd.sv -----
// Command stages: steering and centre average, then speed and output register.
`include "lidar_gap_follow_steer_top_assert.svh"

module lgfs_cmd (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lgfs_pkg::lgfs_cfg_t               cfg_i,
  input  logic                              snap_vld_i,
  output logic                              snap_rdy_o,
  input  lgfs_pkg::lgfs_snap_t              snap_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [lgfs_pkg::SteerW-1:0] steering_o,
  output logic [15:0]                       speed_mm_s_o,
  output logic [lgfs_pkg::LenW-1:0]         gap_length_o,
  output logic [lgfs_pkg::RayW-1:0]         gap_start_o
);
  import lgfs_pkg::*;

  localparam int ProdW = CsumW + DivMulW;
  localparam int SprW  = LenW + 16;
  localparam int SumW  = SprW + 2;
  localparam logic signed [SumW-1:0] StHi = SumW'(SteerMax);
  localparam logic signed [SumW-1:0] StLo = SumW'(SteerMin);

  // stage B
  logic                     b_vld_q, b_vld_d;
  logic [RangeW-1:0]        b_avg_q;
  logic                     b_cinv_q;
  logic signed [SteerW-1:0] b_steer_q;
  logic [LenW-1:0]          b_len_q;
  logic [RayW-1:0]          b_start_q;
  // output stage
  logic                     o_vld_q, o_vld_d;
  logic signed [SteerW-1:0] o_steer_q;
  logic [15:0]              o_speed_q;
  logic [LenW-1:0]          o_len_q;
  logic [RayW-1:0]          o_start_q;

  logic                     b_rdy, c_adv, b_load;
  logic [ProdW-1:0]         avg_prod;
  logic [LenW-1:0]          gsum;
  logic [SprW-1:0]          spr;
  logic signed [SumW-1:0]   st_full;
  logic signed [SteerW-1:0] steer_sat;
  logic [RangeW-1:0]        cdist;
  logic [RangeW-1:0]        diff;
  logic [31:0]              slp_prod;
  logic [24:0]              sp_sum;
  logic [15:0]              speed_sat;

  assign c_adv      = !o_vld_q || out_ready_i;
  assign b_rdy      = !b_vld_q || c_adv;
  assign b_load     = snap_vld_i && b_rdy;
  assign snap_rdy_o = b_rdy;

  // centre average by reciprocal multiply
  assign avg_prod = ProdW'(snap_i.csum) * ProdW'(DivMul);

  // steering toward the gap middle
  assign gsum    = LenW'(snap_i.best.start) + LenW'(snap_i.best.stop);
  assign spr     = SprW'(gsum) * SprW'(cfg_i.half_step);
  assign st_full = SumW'($signed(cfg_i.steer_ofs)) + $signed({2'b00, spr});

  always_comb begin
    if (st_full > StHi)      steer_sat = StHi[SteerW-1:0];
    else if (st_full < StLo) steer_sat = StLo[SteerW-1:0];
    else                     steer_sat = st_full[SteerW-1:0];
  end

  // speed from clamped centre distance
  assign cdist    = (b_cinv_q || (b_avg_q > cfg_i.far_dist)) ? cfg_i.far_dist : b_avg_q;
  assign diff     = cdist - cfg_i.near_dist;
  assign slp_prod = 32'(cfg_i.speed_slope) * 32'(diff);

  always_comb begin
    if (cdist >= cfg_i.near_dist) sp_sum = 25'(cfg_i.turn_speed) + 25'(slp_prod[31:8]);
    else                          sp_sum = 25'(cfg_i.turn_speed);
    speed_sat = (sp_sum[24:16] != '0) ? 16'hFFFF : sp_sum[15:0];
  end

  always_comb begin
    b_vld_d = b_load ? 1'b1 : (c_adv ? 1'b0 : b_vld_q);
    o_vld_d = (b_vld_q && c_adv) ? 1'b1 : (out_ready_i ? 1'b0 : o_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      b_vld_q <= b_vld_d;
      o_vld_q <= o_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_load) begin
      b_avg_q   <= avg_prod[DivShift +: RangeW];
      b_cinv_q  <= snap_i.cinv;
      b_steer_q <= steer_sat;
      b_len_q   <= snap_i.best.len;
      b_start_q <= snap_i.best.start;
    end
    if (b_vld_q && c_adv) begin
      o_steer_q <= b_steer_q;
      o_speed_q <= speed_sat;
      o_len_q   <= b_len_q;
      o_start_q <= b_start_q;
    end
  end

  assign out_valid_o  = o_vld_q;
  assign steering_o   = o_steer_q;
  assign speed_mm_s_o = o_speed_q;
  assign gap_length_o = o_len_q;
  assign gap_start_o  = o_start_q;

  `LGFS_ASSERT_NEXT(a_b_hold, b_vld_q && !c_adv, b_vld_q && $stable(b_avg_q),
    "stage B lost its result while the output was stalled")
  `LGFS_ASSERT_NEXT(a_out_hold, o_vld_q && !out_ready_i,
    o_vld_q && $stable(o_steer_q) && $stable(o_speed_q),
    "output beat changed while the receiver stalled")
  `LGFS_ASSERT_SAME(a_snap_hold, snap_vld_i && !b_rdy, b_vld_q,
    "summary refused while stage B was empty")

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the follow-the-gap lidar steering block.
`timescale 1ns / 100ps

module testbench;
  import lgfs_pkg::*;

  // Scan geometry seen by the predictor (centre window is rays 538..542).
  localparam int CENTRE_FIRST = 538;
  localparam int CENTRE_LAST  = 542;
  localparam int CENTRE_RAYS  = 5;
  localparam int RAY_CAP      = 2048;
  localparam int STEER_TOP    = 4194303;
  localparam int STEER_BOTTOM = -4194304;
  localparam int PHASES       = 9;
  localparam int SHORT_RAYS   = 15;

  // One steering command as it leaves the block.
  typedef struct packed {
    logic signed [22:0] steering;
    logic [15:0]        speed;
    logic [11:0]        gap_len;
    logic [10:0]        gap_start;
  } steer_cmd_t;

  // Gap tracker and command predictor, plus the queue of commands still due.
  class steer_cmd_board;
    lgfs_cfg_t    cfg;
    logic [10:0]  ray_idx;
    logic [11:0]  run_len;
    logic [11:0]  best_len;
    logic [10:0]  best_start;
    logic [10:0]  best_end;
    logic [18:0]  csum;
    bit           cinv;
    steer_cmd_t   cmd_q[$];
    int           errors;
    int           rays;
    int           cmds_seen;

    function new();
      cfg.obst_thr    = 16'd2500;
      cfg.free_lim    = 16'd30000;
      cfg.steer_ofs   = 23'(-1848115);
      cfg.half_step   = 16'd1716;
      cfg.near_dist   = 16'd1500;
      cfg.far_dist    = 16'd5000;
      cfg.turn_speed  = 16'd2000;
      cfg.speed_slope = 16'd146;
      clear_scan();
    endfunction

    function void clear_scan();
      ray_idx    = '0;
      run_len    = '0;
      best_len   = '0;
      best_start = '0;
      best_end   = '0;
      csum       = '0;
      cinv       = 1'b0;
    endfunction

    function void set_reg(lgfs_cfg_idx_e idx, logic [22:0] data);
      case (idx)
        CFG_OBST_THR:   cfg.obst_thr    = data[15:0];
        CFG_FREE_LIM:   cfg.free_lim    = data[15:0];
        CFG_STEER_OFS:  cfg.steer_ofs   = data;
        CFG_HALF_STEP:  cfg.half_step   = data[15:0];
        CFG_NEAR_DIST:  cfg.near_dist   = data[15:0];
        CFG_FAR_DIST:   cfg.far_dist    = data[15:0];
        CFG_TURN_SPEED: cfg.turn_speed  = data[15:0];
        CFG_SPEED_SLP:  cfg.speed_slope = data[15:0];
        default: ;
      endcase
    endfunction

    // Current run competes for best gap; after = index one past its last ray.
    function void offer(int unsigned after);
      if (run_len > best_len) begin
        best_len   = run_len;
        best_start = (run_len > after) ? 11'd0 : 11'(after - run_len);
        best_end   = (after == 0) ? 11'd0 : 11'(after - 1);
      end
    endfunction

    function void take_ray(logic [15:0] rng, logic inv, logic last);
      bit                is_free;
      longint            st;
      longint            ofs;
      longint unsigned   sp;
      int unsigned       d;
      steer_cmd_t        c;
      rays++;
      is_free = inv || rng > cfg.free_lim || rng >= cfg.obst_thr;
      if (ray_idx >= CENTRE_FIRST && ray_idx <= CENTRE_LAST) begin
        if (inv) cinv = 1'b1;
        else csum += rng;
      end
      if (is_free) begin
        if (run_len < RAY_CAP) run_len++;
      end else begin
        offer(ray_idx);
        run_len = '0;
      end
      if (!last) begin
        if (ray_idx < RAY_CAP - 1) ray_idx++;
        return;
      end
      // trailing gap closes at the end of the scan
      offer(ray_idx + 1);
      ofs = $signed(cfg.steer_ofs);
      st  = ofs + (longint'(best_start) + longint'(best_end)) * longint'(cfg.half_step);
      if (st > STEER_TOP) st = STEER_TOP;
      if (st < STEER_BOTTOM) st = STEER_BOTTOM;
      d = csum / CENTRE_RAYS;
      if (cinv || d > cfg.far_dist) d = cfg.far_dist;
      sp = cfg.turn_speed;
      if (d >= cfg.near_dist)
        sp += (longint'(cfg.speed_slope) * longint'(d - cfg.near_dist)) >> 8;
      if (sp > 65535) sp = 65535;
      c.steering  = st[22:0];
      c.speed     = sp[15:0];
      c.gap_len   = best_len;
      c.gap_start = best_start;
      cmd_q.push_back(c);
      clear_scan();
    endfunction

    function int pending();
      return cmd_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_cmd(steer_cmd_t got);
      steer_cmd_t want;
      if (cmd_q.size() == 0) begin
        report($sformatf("unexpected command steering %0d speed %0d len %0d start %0d",
                         got.steering, got.speed, got.gap_len, got.gap_start));
        return;
      end
      want = cmd_q.pop_front();
      cmds_seen++;
      if (got.steering !== want.steering)
        report($sformatf("cmd %0d steering %0d, want %0d", cmds_seen, got.steering,
                         want.steering));
      if (got.speed !== want.speed)
        report($sformatf("cmd %0d speed %0d, want %0d", cmds_seen, got.speed, want.speed));
      if (got.gap_len !== want.gap_len)
        report($sformatf("cmd %0d gap length %0d, want %0d", cmds_seen, got.gap_len,
                         want.gap_len));
      if (got.gap_start !== want.gap_start)
        report($sformatf("cmd %0d gap start %0d, want %0d", cmds_seen, got.gap_start,
                         want.gap_start));
    endtask
  endclass

  // All inputs known from time zero.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx_i   = CFG_OBST_THR;
  logic [CfgDataW-1:0]   cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic [RangeW-1:0]     range_mm_i  = '0;
  logic                  invalid_i   = 1'b0;
  logic                  last_ray_i  = 1'b0;
  logic                  out_ready_i = 1'b0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic signed [SteerW-1:0] steering_o;
  logic [15:0]           speed_mm_s_o;
  logic [LenW-1:0]       gap_length_o;
  logic [RayW-1:0]       gap_start_o;

  steer_cmd_board board;
  int tx_idle_pct  = 0;   // chance per beat that the sender starts an idle burst
  int rx_idle_pct  = 0;   // same for the receiver, per cycle
  int rx_hold_req  = 0;   // long receiver hold-off, handed to the receiver process
  int scans_sent   = 0;

  lidar_gap_follow_steer_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .range_mm_i   (range_mm_i),
    .invalid_i    (invalid_i),
    .last_ray_i   (last_ray_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .steering_o   (steering_o),
    .speed_mm_s_o (speed_mm_s_o),
    .gap_length_o (gap_length_o),
    .gap_start_o  (gap_start_o)
  );

  always #10 clk_i = ~clk_i;

  // 16-bit value biased toward the two extremes.
  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Register set for one phase; kinds 2..6 pin extremes and corner orderings.
  function automatic lgfs_cfg_t make_config(int kind);
    lgfs_cfg_t   c;
    logic [15:0] tmp;
    c.obst_thr    = pick16();
    c.free_lim    = pick16();
    c.steer_ofs   = 23'($urandom);
    c.half_step   = $urandom_range(0, 1) ? 16'($urandom_range(0, 4095)) : pick16();
    c.near_dist   = pick16();
    c.far_dist    = pick16();
    c.turn_speed  = pick16();
    c.speed_slope = pick16();
    case (kind)
      2: begin
        // everything at the top: steering and speed both saturate
        c = '{16'hFFFF, 16'hFFFF, 23'(STEER_TOP), 16'hFFFF, 16'd0, 16'hFFFF,
              16'hFFFF, 16'hFFFF};
      end
      3: begin
        // everything at the bottom: every ray is free, steering pinned low
        c = '{16'd0, 16'd0, 23'(STEER_BOTTOM), 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
      end
      4: begin
        c.near_dist = 16'($urandom_range(1000, 65535));
        c.far_dist  = 16'($urandom_range(0, c.near_dist - 1));
      end
      5: begin
        // free limit under the threshold, so the range cap decides too
        c.obst_thr = 16'($urandom_range(20000, 65535));
        c.free_lim = 16'($urandom_range(0, c.obst_thr - 1));
      end
      6: c.steer_ofs = 23'(STEER_BOTTOM);
      default: begin
        if ($urandom_range(0, 1) && c.near_dist > c.far_dist) begin
          tmp         = c.near_dist;
          c.near_dist = c.far_dist;
          c.far_dist  = tmp;
        end
      end
    endcase
    return c;
  endfunction

  // Value for a ray inside the centre window, mostly between near and far.
  function automatic logic [15:0] centre_range();
    logic [15:0] lo;
    logic [15:0] hi;
    lo = (board.cfg.near_dist < board.cfg.far_dist) ? board.cfg.near_dist : board.cfg.far_dist;
    hi = (board.cfg.near_dist < board.cfg.far_dist) ? board.cfg.far_dist : board.cfg.near_dist;
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  // Ray that lands on the wanted side of the classifier under the current set.
  function automatic void pick_ray(bit want_free, output logic [15:0] rng, output logic inv);
    int hi;
    inv = 1'b0;
    if (want_free || board.cfg.obst_thr == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          inv = 1'b1;
          rng = 16'($urandom);
        end
        1: rng = 16'($urandom_range(board.cfg.obst_thr, 16'hFFFF));
        2: rng = (board.cfg.free_lim == 16'hFFFF) ? 16'hFFFF :
                 16'($urandom_range(board.cfg.free_lim + 1, 16'hFFFF));
        default: rng = 16'hFFFF;
      endcase
    end else begin
      hi = int'(board.cfg.obst_thr) - 1;
      if (hi > board.cfg.free_lim) hi = board.cfg.free_lim;
      case ($urandom_range(0, 3))
        0:       rng = 16'd0;
        1:       rng = 16'(hi);
        default: rng = 16'($urandom_range(0, hi));
      endcase
    end
  endfunction

  task automatic write_reg(lgfs_cfg_idx_e idx, logic [22:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    board.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  // 16-bit registers get junk in the unused upper bits.
  task automatic load_config(lgfs_cfg_t c);
    write_reg(CFG_OBST_THR,   {7'($urandom), c.obst_thr});
    write_reg(CFG_FREE_LIM,   {7'($urandom), c.free_lim});
    write_reg(CFG_STEER_OFS,  c.steer_ofs);
    write_reg(CFG_HALF_STEP,  {7'($urandom), c.half_step});
    write_reg(CFG_NEAR_DIST,  {7'($urandom), c.near_dist});
    write_reg(CFG_FAR_DIST,   {7'($urandom), c.far_dist});
    write_reg(CFG_TURN_SPEED, {7'($urandom), c.turn_speed});
    write_reg(CFG_SPEED_SLP,  {7'($urandom), c.speed_slope});
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid and wait out every pending command plus the pipeline depth.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic maybe_idle_tx();
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // One ray beat; valid stays up afterwards so back-to-back beats need no gap.
  task automatic send_ray(logic [15:0] rng, logic inv, logic last);
    range_mm_i <= rng;
    invalid_i  <= inv;
    last_ray_i <= last;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    board.take_ray(rng, inv, last);
  endtask

  // Whole scan. flip_odds: 1-in-N chance per ray of toggling free/obstacle
  // (0 = all free, centre window not special). obst_at forces one obstacle.
  task automatic send_scan(int len, int flip_odds, int obst_at);
    int          i;
    int          bad_ray;
    bit          want_free;
    logic [15:0] rng;
    logic        inv;
    want_free = (flip_odds == 0) ? 1'b1 : 1'($urandom_range(0, 1));
    bad_ray   = ($urandom_range(0, 2) == 0) ?
                int'($urandom_range(CENTRE_FIRST, CENTRE_LAST)) : -1;
    scans_sent++;
    for (i = 0; i < len; i++) begin
      maybe_idle_tx();
      if (flip_odds != 0 && $urandom_range(1, flip_odds) == 1) want_free = !want_free;
      if (flip_odds != 0 && i >= CENTRE_FIRST && i <= CENTRE_LAST) begin
        rng = centre_range();
        inv = (i == bad_ray);
      end else if (i == obst_at) begin
        rng = 16'd0;
        inv = 1'b0;
      end else begin
        pick_ray(want_free, rng, inv);
      end
      send_ray(rng, inv, i == len - 1);
    end
  endtask

  // Receiver: checks each command beat, then decides ready for the next
  // cycle. Stall bursts and the long hold-off are counted here.
  initial begin : cmd_sink
    int         stall;
    steer_cmd_t got;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.steering  = steering_o;
        got.speed     = speed_mm_s_o;
        got.gap_len   = gap_length_o;
        got.gap_start = gap_start_o;
        board.check_cmd(got);
      end
      if (rx_hold_req > 0) begin
        stall       = rx_hold_req;
        rx_hold_req = 0;
      end else if (stall == 0 && rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        stall = $urandom_range(1, 12);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed scans at reset values, then phases that
  // each load a register set (all but the first) and run random scans.
  initial begin : stimulus
    int phase;
    int short_rays;
    int n;
    bit paused;
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No gap at all: a lone obstacle ray, steering is just the offset.
    send_ray(16'd0, 1'b0, 1'b1);
    // Lone free ray, closed as a trailing gap.
    send_ray(16'hFFFF, 1'b0, 1'b1);
    // Lone invalid ray counts as free.
    send_ray(16'd0, 1'b1, 1'b1);
    // Threshold edges: just below is obstacle, equal is free; the trailing
    // run of three beats the earlier run of two.
    send_ray(16'd2499, 1'b0, 1'b0);
    send_ray(16'd2500, 1'b0, 1'b0);
    send_ray(16'd30000, 1'b0, 1'b0);
    send_ray(16'd0, 1'b0, 1'b0);
    send_ray(16'd30001, 1'b0, 1'b0);
    send_ray(16'hFFFF, 1'b1, 1'b0);
    send_ray(16'd40000, 1'b0, 1'b1);
    // Equal runs: the first one stays best.
    send_ray(16'd9000, 1'b0, 1'b0);
    send_ray(16'd100, 1'b0, 1'b0);
    send_ray(16'd9000, 1'b0, 1'b1);
    // Scan ends on an obstacle.
    send_ray(16'hFFFF, 1'b0, 1'b0);
    send_ray(16'hFFFF, 1'b0, 1'b0);
    send_ray(16'd1, 1'b0, 1'b1);

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        settle();
        load_config(make_config(phase));
      end
      // last phase runs flat out on both sides
      if (phase == PHASES - 1) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       tx_idle_pct = 0;
          1:       tx_idle_pct = 10;
          default: tx_idle_pct = 35;
        endcase
        case ($urandom_range(0, 2))
          0:       rx_idle_pct = 0;
          1:       rx_idle_pct = 10;
          default: rx_idle_pct = 35;
        endcase
      end

      if (phase == 3) begin
        // output held off for a long stretch while single-ray scans keep
        // coming: pipeline fills and the input must back up
        tx_idle_pct = 0;
        rx_hold_req = 300;
        repeat (40) send_scan(1, 4, -1);
      end

      short_rays = 0;
      paused     = 1'b0;
      while (short_rays < SHORT_RAYS) begin
        n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 16);
        send_scan(n, 4, -1);
        short_rays += n;
        if (phase == 5 && !paused && short_rays > SHORT_RAYS / 2) begin
          // sender drains the block completely mid-phase
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (board.pending() != 0);
          paused = 1'b1;
        end
      end

      // one scan long enough to reach the centre window, maybe ending inside it
      if (phase == PHASES - 1) send_scan($urandom_range(540, 560), 24, -1);
    end

    settle();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d rays in %0d scans, %0d steering commands compared.",
             board.rays, scans_sent, board.cmds_seen);
    $display("Covered %0d register sets incl. extremes, a long output stall and a centre scan.",
             PHASES);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run guard: well above the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/lgfs_pkg.sv
sv/lgfs_cfg.sv
sv/lgfs_scan.sv
sv/lgfs_cmd.sv
sv/lidar_gap_follow_steer_top.sv
tb/testbench.sv
